FILE: rtl/config_text_tokenizer_top_macros.svh
// Assertion macros for the configuration text tokenizer checker
`ifndef CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CTT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, off during reset
`define CTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// what must follow a reset cycle
`define CTT_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/ctt_pkg.sv
// Shared types, constants and helpers for the configuration text tokenizer
`timescale 1ns / 1ps

package ctt_pkg;

  localparam int POS_BITS = 16;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int OUT_TDATA_W = 56;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  localparam logic [3:0] K_LBRACE   = 4'd0;
  localparam logic [3:0] K_RBRACE   = 4'd1;
  localparam logic [3:0] K_LBRACKET = 4'd2;
  localparam logic [3:0] K_RBRACKET = 4'd3;
  localparam logic [3:0] K_EQUALS   = 4'd4;
  localparam logic [3:0] K_COMMA    = 4'd5;
  localparam logic [3:0] K_INT      = 4'd6;
  localparam logic [3:0] K_STRING   = 4'd7;
  localparam logic [3:0] K_IDENT    = 4'd8;
  localparam logic [3:0] K_NEWLINE  = 4'd9;
  localparam logic [3:0] K_COMMENT  = 4'd10;
  localparam logic [3:0] K_WS       = 4'd11;
  localparam logic [3:0] K_EOF      = 4'd12;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_STRING  = 2'd1;
  localparam logic [1:0] ERR_SIGN    = 2'd2;
  localparam logic [1:0] ERR_INVALID = 2'd3;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DQUOTE   = 8'h22;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_EQUALS   = 8'h3D;
  localparam logic [7:0] CH_UA       = 8'h41;
  localparam logic [7:0] CH_UZ       = 8'h5A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_USCORE   = 8'h5F;
  localparam logic [7:0] CH_LA       = 8'h61;
  localparam logic [7:0] CH_LZ       = 8'h7A;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  err;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t r0;
    tok_t r1;
  } evt_t;

  function automatic logic [15:0] pos_out(input logic [POS_BITS-1:0] p);
    logic [POS_BITS+15:0] w;
    w = {16'd0, p};
    return w[15:0];
  endfunction

endpackage

FILE: rtl/config_text_tokenizer_top.sv
// A byte's results are registered in the event queue, then in the output register.
// One byte per cycle in while the queue is not full; one result per cycle out
// while out_tready allows, so a byte giving two results sends them in turn,
// absorbed by a 4-entry event queue between the lexer and the output register.
// Reset (synchronous, rst_n low) empties the queue and output, returns the
// lexer to line 1 column 1 between tokens, and clears skip_trivia.
`timescale 1ns / 1ps

module config_text_tokenizer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // data_byte
  input  logic [0:0]                      in_tuser,   // end_mark
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // error_code, start_line, start_col, lexeme_length, zero fill
  output logic [ctt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [3:0]                      out_tuser,  // token_kind
  output logic                            out_tlast
);

  logic          q_full, evt_valid, q_valid, q_pop;
  ctt_pkg::evt_t evt, q_data;
  ctt_pkg::tok_t out_tok;

  ctt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .data_byte   (in_tdata),
    .end_mark    (in_tuser[0]),
    .q_full      (q_full),
    .evt_valid   (evt_valid),
    .evt         (evt)
  );

  ctt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_valid),
    .push_data (evt),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ctt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  assign out_tdata = {6'd0, out_tok.len, out_tok.col, out_tok.line, out_tok.err};
  assign out_tuser = out_tok.kind;
  assign out_tlast = out_tok.last;

endmodule

FILE: rtl/ctt_front.sv
// Front end: accepts bytes, runs the lexer state machine, forms result events
`timescale 1ns / 1ps

module ctt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              end_mark,
  input  logic              q_full,
  output logic              evt_valid,
  output ctt_pkg::evt_t     evt
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_STR     = 4'd1;
  localparam logic [3:0] M_ESC     = 4'd2;
  localparam logic [3:0] M_SIGN    = 4'd3;
  localparam logic [3:0] M_INT     = 4'd4;
  localparam logic [3:0] M_COMMENT = 4'd5;
  localparam logic [3:0] M_WS      = 4'd6;
  localparam logic [3:0] M_IDENT   = 4'd7;
  localparam logic [3:0] M_HALT    = 4'd8;

  logic [3:0]                   mode_r, mode_nxt;
  logic [ctt_pkg::POS_BITS-1:0] cur_line_r, cur_line_nxt, cur_col_r, cur_col_nxt;
  logic [ctt_pkg::POS_BITS-1:0] tok_line_r, tok_line_nxt, tok_col_r, tok_col_nxt;
  logic [ctt_pkg::POS_BITS-1:0] adv_line, adv_col;
  logic [15:0]                  tok_len_r, tok_len_nxt, sat_len;
  logic [16:0]                  len_sum;
  logic [1:0]                   len_inc;
  logic                         skip_r;
  logic                         acc, is_end, is_dig, is_idc, is_nl, is_blank;
  logic                         st_em;
  logic [3:0]                   st_kind, st_mode;
  logic [1:0]                   st_err;
  logic [15:0]                  st_len;
  logic                         ema, emb, ema_k, emb_k, do_start;
  logic [3:0]                   ka, kb;
  logic [1:0]                   ea, eb;
  logic [15:0]                  lb;
  ctt_pkg::tok_t                ra, rb;

  function automatic logic keep(input logic [3:0] k, input logic [1:0] e, input logic s);
    return (e != ctt_pkg::ERR_NONE) ||
           !(s && (k == ctt_pkg::K_WS || k == ctt_pkg::K_COMMENT ||
                   k == ctt_pkg::K_NEWLINE));
  endfunction

  function automatic ctt_pkg::tok_t mk_tok(input logic [3:0] k, input logic [1:0] e,
                                           input logic [ctt_pkg::POS_BITS-1:0] l,
                                           input logic [ctt_pkg::POS_BITS-1:0] c,
                                           input logic [15:0] n);
    ctt_pkg::tok_t t;
    t.kind = (e != ctt_pkg::ERR_NONE) ? 4'd0 : k;
    t.err  = e;
    t.line = ctt_pkg::pos_out(l);
    t.col  = ctt_pkg::pos_out(c);
    t.len  = n;
    t.last = 1'b0;
    return t;
  endfunction

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;

  assign is_end   = end_mark || (data_byte == ctt_pkg::CH_NUL);
  assign is_dig   = (data_byte >= ctt_pkg::CH_0) && (data_byte <= ctt_pkg::CH_9);
  assign is_idc   = ((data_byte >= ctt_pkg::CH_LA) && (data_byte <= ctt_pkg::CH_LZ)) ||
                    ((data_byte >= ctt_pkg::CH_UA) && (data_byte <= ctt_pkg::CH_UZ)) ||
                    is_dig || (data_byte == ctt_pkg::CH_USCORE);
  assign is_nl    = (data_byte == ctt_pkg::CH_NL);
  assign is_blank = (data_byte == ctt_pkg::CH_SPACE) || (data_byte == ctt_pkg::CH_TAB);

  assign adv_line = !is_nl ? cur_line_r :
                    (cur_line_r == ctt_pkg::POS_MAX) ? cur_line_r : cur_line_r + ctt_pkg::POS_ONE;
  assign adv_col  = is_nl ? ctt_pkg::POS_ONE :
                    (cur_col_r == ctt_pkg::POS_MAX) ? cur_col_r : cur_col_r + ctt_pkg::POS_ONE;

  assign len_inc  = (mode_r == M_ESC && data_byte != ctt_pkg::CH_DQUOTE) ? 2'd2 : 2'd1;
  assign len_sum  = {1'b0, tok_len_r} + 17'(len_inc);
  assign sat_len  = len_sum[16] ? 16'hFFFF : len_sum[15:0];

  always_comb begin
    st_em   = 1'b1;
    st_kind = ctt_pkg::K_LBRACE;
    st_err  = ctt_pkg::ERR_NONE;
    st_len  = 16'd1;
    st_mode = M_IDLE;
    unique case (data_byte) inside
      ctt_pkg::CH_LBRACE:   st_kind = ctt_pkg::K_LBRACE;
      ctt_pkg::CH_RBRACE:   st_kind = ctt_pkg::K_RBRACE;
      ctt_pkg::CH_LBRACKET: st_kind = ctt_pkg::K_LBRACKET;
      ctt_pkg::CH_RBRACKET: st_kind = ctt_pkg::K_RBRACKET;
      ctt_pkg::CH_EQUALS:   st_kind = ctt_pkg::K_EQUALS;
      ctt_pkg::CH_COMMA:    st_kind = ctt_pkg::K_COMMA;
      ctt_pkg::CH_NL:       st_kind = ctt_pkg::K_NEWLINE;
      ctt_pkg::CH_DQUOTE: begin
        st_em   = 1'b0;
        st_len  = 16'd0;
        st_mode = M_STR;
      end
      ctt_pkg::CH_MINUS, ctt_pkg::CH_PLUS: begin
        st_em   = 1'b0;
        st_mode = M_SIGN;
      end
      ctt_pkg::CH_HASH: begin
        st_em   = 1'b0;
        st_mode = M_COMMENT;
      end
      ctt_pkg::CH_SPACE, ctt_pkg::CH_TAB: begin
        st_em   = 1'b0;
        st_mode = M_WS;
      end
      default: begin
        if (is_dig) begin
          st_em   = 1'b0;
          st_mode = M_INT;
        end else if (is_idc) begin
          st_em   = 1'b0;
          st_mode = M_IDENT;
        end else begin
          st_err  = ctt_pkg::ERR_INVALID;
          st_len  = 16'd0;
          st_mode = M_HALT;
        end
      end
    endcase
  end

  always_comb begin
    mode_nxt     = mode_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    tok_len_nxt  = tok_len_r;
    ema          = 1'b0;
    emb          = 1'b0;
    ka           = ctt_pkg::K_LBRACE;
    kb           = ctt_pkg::K_LBRACE;
    ea           = ctt_pkg::ERR_NONE;
    eb           = ctt_pkg::ERR_NONE;
    lb           = 16'd0;
    do_start     = 1'b0;
    if (is_end) begin
      unique case (mode_r)
        M_STR, M_ESC: begin
          ema = 1'b1;
          ea  = ctt_pkg::ERR_STRING;
        end
        M_SIGN: begin
          ema = 1'b1;
          ea  = ctt_pkg::ERR_SIGN;
        end
        M_INT: begin
          ema = 1'b1;
          ka  = ctt_pkg::K_INT;
        end
        M_COMMENT: begin
          ema = 1'b1;
          ka  = ctt_pkg::K_COMMENT;
        end
        M_WS: begin
          ema = 1'b1;
          ka  = ctt_pkg::K_WS;
        end
        M_IDENT: begin
          ema = 1'b1;
          ka  = ctt_pkg::K_IDENT;
        end
        default: ema = 1'b0;
      endcase
      if (mode_r == M_IDLE || mode_r == M_INT || mode_r == M_COMMENT ||
          mode_r == M_WS || mode_r == M_IDENT) begin
        emb = 1'b1;
        kb  = ctt_pkg::K_EOF;
      end
      mode_nxt     = M_IDLE;
      cur_line_nxt = ctt_pkg::POS_ONE;
      cur_col_nxt  = ctt_pkg::POS_ONE;
      tok_line_nxt = ctt_pkg::POS_ONE;
      tok_col_nxt  = ctt_pkg::POS_ONE;
      tok_len_nxt  = 16'd0;
    end else begin
      if (mode_r != M_HALT) begin
        cur_line_nxt = adv_line;
        cur_col_nxt  = adv_col;
      end
      unique case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_STR: begin
          if (data_byte == ctt_pkg::CH_BSLASH) begin
            mode_nxt = M_ESC;
          end else if (data_byte == ctt_pkg::CH_DQUOTE) begin
            ema      = 1'b1;
            ka       = ctt_pkg::K_STRING;
            mode_nxt = M_IDLE;
          end else begin
            tok_len_nxt = sat_len;
          end
        end
        M_ESC: begin
          tok_len_nxt = sat_len;
          mode_nxt    = M_STR;
        end
        M_SIGN: begin
          if (is_dig) begin
            tok_len_nxt = sat_len;
            mode_nxt    = M_INT;
          end else begin
            ema      = 1'b1;
            ea       = ctt_pkg::ERR_SIGN;
            mode_nxt = M_HALT;
          end
        end
        M_INT: begin
          if (is_dig) begin
            tok_len_nxt = sat_len;
          end else begin
            ema      = 1'b1;
            ka       = ctt_pkg::K_INT;
            do_start = 1'b1;
          end
        end
        M_COMMENT: begin
          if (!is_nl) begin
            tok_len_nxt = sat_len;
          end else begin
            ema      = 1'b1;
            ka       = ctt_pkg::K_COMMENT;
            do_start = 1'b1;
          end
        end
        M_WS: begin
          if (is_blank) begin
            tok_len_nxt = sat_len;
          end else begin
            ema      = 1'b1;
            ka       = ctt_pkg::K_WS;
            do_start = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_idc) begin
            tok_len_nxt = sat_len;
          end else begin
            ema      = 1'b1;
            ka       = ctt_pkg::K_IDENT;
            do_start = 1'b1;
          end
        end
        default: mode_nxt = M_HALT;
      endcase
      if (do_start) begin
        tok_line_nxt = cur_line_r;
        tok_col_nxt  = cur_col_r;
        tok_len_nxt  = st_len;
        mode_nxt     = st_mode;
        emb          = st_em;
        kb           = st_kind;
        eb           = st_err;
        lb           = st_len;
      end
    end
  end

  assign ema_k = ema && keep(ka, ea, skip_r);
  assign emb_k = emb && keep(kb, eb, skip_r);

  always_comb begin
    ra        = mk_tok(ka, ea, tok_line_r, tok_col_r, tok_len_r);
    rb        = mk_tok(kb, eb, cur_line_r, cur_col_r, lb);
    evt.two   = ema_k && emb_k;
    evt.r0    = ema_k ? ra : rb;
    evt.r0.last = !(ema_k && emb_k);
    evt.r1    = rb;
    evt.r1.last = 1'b1;
  end

  assign evt_valid = acc && (ema_k || emb_k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      cur_line_r <= ctt_pkg::POS_ONE;
      cur_col_r  <= ctt_pkg::POS_ONE;
      tok_line_r <= ctt_pkg::POS_ONE;
      tok_col_r  <= ctt_pkg::POS_ONE;
      tok_len_r  <= 16'd0;
      skip_r     <= 1'b0;
    end else begin
      if (acc) begin
        mode_r     <= mode_nxt;
        cur_line_r <= cur_line_nxt;
        cur_col_r  <= cur_col_nxt;
        tok_line_r <= tok_line_nxt;
        tok_col_r  <= tok_col_nxt;
        tok_len_r  <= tok_len_nxt;
      end
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
    end
  end

endmodule

FILE: rtl/ctt_queue.sv
// Event queue between the lexer front end and the result back end
`timescale 1ns / 1ps

module ctt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ctt_pkg::evt_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output ctt_pkg::evt_t q_data
);

  localparam logic [ctt_pkg::QPTR_BITS:0] CNT_FULL = (ctt_pkg::QPTR_BITS+1)'(ctt_pkg::QDEPTH);

  ctt_pkg::evt_t                mem [ctt_pkg::QDEPTH];
  logic [ctt_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [ctt_pkg::QPTR_BITS:0]   cnt_r;

  assign full    = (cnt_r == CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/ctt_back.sv
// Back end: splits queued events into single results behind an output register
`timescale 1ns / 1ps

module ctt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ctt_pkg::evt_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ctt_pkg::tok_t out_tok
);

  logic          out_valid_r, out_valid_nxt, pend_v_r, pend_v_nxt, load;
  ctt_pkg::tok_t out_r, out_nxt, pend_r, pend_nxt;

  assign load  = !out_valid_r || out_ready;
  assign q_pop = load && !pend_v_r && q_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    if (load) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        pend_v_nxt    = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_nxt       = q_data.r0;
        pend_v_nxt    = q_data.two;
        pend_nxt      = q_data.r1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_tok   = out_r;

endmodule

FILE: rtl/ctt_checker.sv
// Port-level checker for the configuration text tokenizer, bound to the top level
`timescale 1ns / 1ps
`include "config_text_tokenizer_top_macros.svh"

module ctt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ctt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [3:0]                      out_tuser,
  input logic                            out_tlast
);

  logic is_err, is_eof;

  assign is_err = (out_tdata[1:0] != ctt_pkg::ERR_NONE);
  assign is_eof = (out_tuser == ctt_pkg::K_EOF);

  `CTT_ASSERT_RST(a_rst_no_out, !out_tvalid)
  `CTT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CTT_ASSERT_SAME(a_err_last, out_tvalid && is_err, out_tlast && out_tuser == ctt_pkg::K_LBRACE)
  `CTT_ASSERT_SAME(a_eof_last, out_tvalid && is_eof, out_tlast && out_tdata[49:34] == 16'd0)

endmodule

bind config_text_tokenizer_top ctt_checker u_ctt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
